>>> rtl/joint_angle_servo_mapper_assert.svh
// Assertion macros used by the top block of the joint angle servo mapper.
`ifndef JOINT_ANGLE_SERVO_MAPPER_ASSERT_SVH
`define JOINT_ANGLE_SERVO_MAPPER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JASM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define JASM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/jasm_pkg.sv
package jasm_pkg;

    localparam int HISTORY_DEPTH = 5;
    localparam int CORDIC_STEPS  = 16;

    localparam int COORD_W = 16;
    localparam int ANGLE_W = 16;
    localparam int PULSE_W = 12;
    localparam int GRAB_W  = 16;
    localparam int CFG_W   = 16;

    localparam int XY_W       = 28;
    localparam int CORDIC_Z_W = 26;
    localparam int TAB_LEN    = 24;
    localparam int TAB_IDX_W  = $clog2(TAB_LEN);
    localparam int STEP_W     = $clog2(CORDIC_STEPS);

    localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
    localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int SUM_W  = ANGLE_W + FILL_W;

    localparam int PROD_W  = ANGLE_W + PULSE_W + 2;
    localparam int DIV_N_W = 28;
    localparam int DIV_D_W = 16;
    localparam int CNT_MAX = (DIV_N_W > CORDIC_STEPS) ? DIV_N_W : CORDIC_STEPS;
    localparam int CNT_W   = $clog2(CNT_MAX);

    // The map divides by 46080 = 1024 * 45: a shift by 10, then a multiplication by
    // the rounded-up reciprocal of 45, exact for every 18-bit shifted product.
    localparam int MAP_SHIFT       = 10;
    localparam int MAP_N_W         = 18;
    localparam int MAP_RECIP_W     = 19;
    localparam int MAP_RECIP_SHIFT = 24;
    localparam int MAP_PROD_W      = MAP_N_W + MAP_RECIP_W;
    localparam logic [MAP_RECIP_W-1:0] MAP_RECIP = MAP_RECIP_W'(372828);

    localparam int JOINTS = 3;
    localparam int VECS   = 4;

    localparam logic signed [CORDIC_Z_W-1:0] DEG90_Q16  = CORDIC_Z_W'(5898240);
    localparam logic signed [CORDIC_Z_W:0]   DEG180_Q16 = (CORDIC_Z_W + 1)'(11796480);
    localparam logic signed [CORDIC_Z_W:0]   DEG360_Q16 = (CORDIC_Z_W + 1)'(23592960);
    localparam logic [DIV_D_W-1:0]           SPAN_Q88   = DIV_D_W'(46080);

    localparam logic [PULSE_W-1:0] PULSE_MIN_RESET     = PULSE_W'(150);
    localparam logic [PULSE_W-1:0] PULSE_MAX_RESET     = PULSE_W'(600);
    localparam logic [GRAB_W-1:0]  GRAB_DISTANCE_RESET = GRAB_W'(3277);

    localparam int ATAN_TABLE [TAB_LEN] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef enum logic [1:0] {
        REG_PULSE_MIN     = 2'd0,
        REG_PULSE_MAX     = 2'd1,
        REG_GRAB_DISTANCE = 2'd2
    } reg_index_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROT,
        S_STORE,
        S_SUM,
        S_AVG_LOAD,
        S_AVG,
        S_MUL,
        S_MAP,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [COORD_W-1:0] shoulder_x;
        logic [COORD_W-1:0] shoulder_y;
        logic [COORD_W-1:0] elbow_x;
        logic [COORD_W-1:0] elbow_y;
        logic [COORD_W-1:0] wrist_x;
        logic [COORD_W-1:0] wrist_y;
        logic [COORD_W-1:0] thumb_x;
        logic [COORD_W-1:0] thumb_y;
        logic [COORD_W-1:0] index_x;
        logic [COORD_W-1:0] index_y;
    } frame_t;

    typedef struct packed {
        logic [PULSE_W-1:0] shoulder_pulse;
        logic [PULSE_W-1:0] elbow_pulse;
        logic [PULSE_W-1:0] wrist_pulse;
        logic [PULSE_W-1:0] grip_pulse;
        logic               grab;
    } pulse_t;

    typedef struct packed {
        logic start;
        logic run;
    } step_ctrl_t;

    function automatic logic [ANGLE_W-1:0] joint_angle(
        input logic signed [CORDIC_Z_W-1:0] zc,
        input logic signed [CORDIC_Z_W-1:0] za
    );
        logic signed [CORDIC_Z_W:0] d;
        d = {zc[CORDIC_Z_W-1], zc} - {za[CORDIC_Z_W-1], za};
        if (d < 0)
        begin
            d = -d;
        end
        if (d > DEG180_Q16)
        begin
            d = DEG360_Q16 - d;
        end
        if (d < 0)
        begin
            d = '0;
        end
        return d[ANGLE_W+7:8];
    endfunction

endpackage

>>> rtl/jasm_if.sv
interface jasm_frame_if import jasm_pkg::*; ();
    logic   valid;
    logic   ready;
    frame_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface jasm_pulse_if import jasm_pkg::*; ();
    logic   valid;
    logic   ready;
    pulse_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/jasm_cordic_lane.sv
module jasm_cordic_lane import jasm_pkg::*; (
    input  logic                         clk,
    input  step_ctrl_t                   ctrl,
    input  logic [STEP_W-1:0]            step,
    input  logic signed [COORD_W:0]      dx,
    input  logic signed [COORD_W:0]      dy,
    output logic signed [CORDIC_Z_W-1:0] z
);

    logic signed [XY_W-1:0]       x_reg, x_next, y_reg, y_next;
    logic signed [XY_W-1:0]       x0, y0, xs, ys;
    logic signed [CORDIC_Z_W-1:0] z_reg, z_next, atan;
    logic                         zero_reg, zero_next;

    assign x0   = {{(XY_W - COORD_W - 9){dx[COORD_W]}}, dx, 8'b0};
    assign y0   = {{(XY_W - COORD_W - 9){dy[COORD_W]}}, dy, 8'b0};
    assign xs   = x_reg >>> step;
    assign ys   = y_reg >>> step;
    assign atan = CORDIC_Z_W'(ATAN_TABLE[TAB_IDX_W'(step)]);

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        zero_next = zero_reg;
        if (ctrl.start)
        begin
            zero_next = (dx == '0) && (dy == '0);
            if (x0 < 0)
            begin
                if (y0 >= 0)
                begin
                    x_next = y0;
                    y_next = -x0;
                    z_next = DEG90_Q16;
                end
                else
                begin
                    x_next = -y0;
                    y_next = x0;
                    z_next = -DEG90_Q16;
                end
            end
            else
            begin
                x_next = x0;
                y_next = y0;
                z_next = '0;
            end
        end
        else if (ctrl.run)
        begin
            if (y_reg >= 0)
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + atan;
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - atan;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        zero_reg <= zero_next;
    end

    assign z = zero_reg ? '0 : z_reg;

endmodule

>>> rtl/jasm_div.sv
module jasm_div import jasm_pkg::*; (
    input  logic               clk,
    input  step_ctrl_t         ctrl,
    input  logic [DIV_N_W-1:0] num,
    input  logic [DIV_D_W-1:0] den,
    output logic [DIV_N_W-1:0] quo
);

    logic [DIV_D_W-1:0] rem_reg, rem_next, den_reg;
    logic [DIV_N_W-1:0] quo_reg, quo_next;
    logic [DIV_D_W:0]   trial;
    logic               fits;

    assign trial = {rem_reg, quo_reg[DIV_N_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (ctrl.start)
        begin
            rem_next = '0;
            quo_next = num;
        end
        else if (ctrl.run)
        begin
            rem_next = fits ? DIV_D_W'(trial - {1'b0, den_reg}) : DIV_D_W'(trial);
            quo_next = {quo_reg[DIV_N_W-2:0], fits};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (ctrl.start)
        begin
            den_reg <= den;
        end
    end

    assign quo = quo_reg;

endmodule

>>> rtl/jasm_merge.sv
module jasm_merge import jasm_pkg::*; (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         write,
    input  logic signed [CORDIC_Z_W-1:0] z [VECS],
    output logic [SUM_W-1:0]             sum [JOINTS],
    output logic [FILL_W-1:0]            fill
);

    logic [ANGLE_W-1:0] angle [JOINTS];
    logic [ANGLE_W-1:0] hist_reg [JOINTS][HISTORY_DEPTH];
    logic [SUM_W-1:0]   sum_reg [JOINTS];
    logic [SUM_W-1:0]   sum_next [JOINTS];
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;

    // Vectors: 0 shoulder-elbow, 1 wrist-elbow, 2 elbow-shoulder, 3 wrist-shoulder.
    assign angle[0] = joint_angle(z[1], z[0]);
    assign angle[1] = joint_angle(z[3], z[2]);
    assign angle[2] = joint_angle(z[0], z[1]);

    always_comb
    begin
        slot_next = slot_reg;
        fill_next = fill_reg;
        if (write)
        begin
            slot_next = (slot_reg == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
            if (fill_reg < FILL_W'(HISTORY_DEPTH))
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < JOINTS; j++)
        begin
            if (write)
            begin
                hist_reg[j][slot_reg] <= angle[j];
            end
            sum_reg[j] <= sum_next[j];
        end
    end

    always_comb
    begin
        for (int j = 0; j < JOINTS; j++)
        begin
            sum_next[j] = '0;
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                if (FILL_W'(i) < fill_reg)
                begin
                    sum_next[j] = sum_next[j] + SUM_W'(hist_reg[j][i]);
                end
            end
        end
    end

    assign sum  = sum_reg;
    assign fill = fill_reg;

endmodule

>>> rtl/joint_angle_servo_mapper.sv
// Channel   Direction  Handshake     Payload
// frame     in         valid/ready   five tracked points, ten 16-bit coordinates
// pulse     out        valid/ready   four 12-bit servo pulses and the grab flag
// cfg       in         cfg_we        register index and 16-bit write data
//
// One frame passes through CORDIC iteration in four lanes, storing and summing of the
// history, a restoring division for the averages, and mapping and loading of the result.
// A frame is not taken before the last one's result is in the output register; the next
// frame can be taken in the cycle after that. Reset is asynchronous and clears the
// history fill count. A stalled output holds its result while the next frame is worked on.
`include "joint_angle_servo_mapper_assert.svh"

module joint_angle_servo_mapper import jasm_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    jasm_frame_if.sink         frame,
    jasm_pulse_if.source       pulse,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [CFG_W-1:0]   cfg_data
);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    step_ctrl_t          lane_ctrl, div_ctrl;
    logic                merge_write, load_out;

    logic [PULSE_W-1:0]  pulse_min_reg, pulse_max_reg;
    logic [GRAB_W-1:0]   grab_distance_reg;

    frame_t              frame_reg;
    pulse_t              out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic signed [COORD_W:0]      vdx [VECS];
    logic signed [COORD_W:0]      vdy [VECS];
    logic signed [CORDIC_Z_W-1:0] vz  [VECS];
    logic [SUM_W-1:0]             sum [JOINTS];
    logic [FILL_W-1:0]            fill;

    logic [DIV_N_W-1:0]           div_num [JOINTS];
    logic [DIV_D_W-1:0]           div_den;
    logic [DIV_N_W-1:0]           div_quo [JOINTS];
    logic signed [PROD_W-1:0]     prod_reg [JOINTS];
    logic [PROD_W-1:0]            prod_mag [JOINTS];
    logic [MAP_PROD_W-1:0]        recip_reg [JOINTS];
    logic [PULSE_W-1:0]           map_quo [JOINTS];
    logic [PULSE_W-1:0]           jpulse [JOINTS];

    logic signed [PULSE_W:0]      span, half;
    logic signed [COORD_W:0]      gx, gy;
    logic [2*COORD_W-1:0]         sqx_reg, sqy_reg;
    logic [2*GRAB_W-1:0]          thr_reg;
    logic                         grab;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_min_reg     <= PULSE_MIN_RESET;
            pulse_max_reg     <= PULSE_MAX_RESET;
            grab_distance_reg <= GRAB_DISTANCE_RESET;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_PULSE_MIN:     pulse_min_reg     <= cfg_data[PULSE_W-1:0];
                REG_PULSE_MAX:     pulse_max_reg     <= cfg_data[PULSE_W-1:0];
                REG_GRAB_DISTANCE: grab_distance_reg <= cfg_data[GRAB_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:     if (frame.valid) state_next = S_ROT;
            S_ROT:      if (cnt_reg == CNT_W'(CORDIC_STEPS - 1)) state_next = S_STORE;
            S_STORE:    state_next = S_SUM;
            S_SUM:      state_next = S_AVG_LOAD;
            S_AVG_LOAD: state_next = S_AVG;
            S_AVG:      if (cnt_reg == CNT_W'(DIV_N_W - 1)) state_next = S_MUL;
            S_MUL:      state_next = S_MAP;
            S_MAP:      state_next = S_DONE;
            S_DONE:     if (!out_valid_reg || pulse.ready) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        frame.ready    = 1'b0;
        lane_ctrl      = '0;
        div_ctrl       = '0;
        merge_write    = 1'b0;
        load_out       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                frame.ready     = 1'b1;
                lane_ctrl.start = frame.valid;
            end
            S_ROT:      lane_ctrl.run  = 1'b1;
            S_STORE:    merge_write    = 1'b1;
            S_AVG_LOAD: div_ctrl.start = 1'b1;
            S_AVG:      div_ctrl.run   = 1'b1;
            S_DONE:     load_out = !out_valid_reg || pulse.ready;
            default:    ;
        endcase
    end

    assign cnt_next = (lane_ctrl.run || div_ctrl.run) ? cnt_reg + 1'b1 : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= (state_next == state_reg) ? cnt_next : '0;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid_next = load_out || (out_valid_reg && !pulse.ready);

    always_ff @(posedge clk)
    begin
        if (frame.valid && frame.ready)
        begin
            frame_reg <= frame.data;
        end
        if (load_out)
        begin
            out_reg <= out_next;
        end
    end

    assign vdx[0] = $signed({1'b0, frame.data.shoulder_x}) - $signed({1'b0, frame.data.elbow_x});
    assign vdy[0] = $signed({1'b0, frame.data.shoulder_y}) - $signed({1'b0, frame.data.elbow_y});
    assign vdx[1] = $signed({1'b0, frame.data.wrist_x}) - $signed({1'b0, frame.data.elbow_x});
    assign vdy[1] = $signed({1'b0, frame.data.wrist_y}) - $signed({1'b0, frame.data.elbow_y});
    assign vdx[2] = $signed({1'b0, frame.data.elbow_x}) - $signed({1'b0, frame.data.shoulder_x});
    assign vdy[2] = $signed({1'b0, frame.data.elbow_y}) - $signed({1'b0, frame.data.shoulder_y});
    assign vdx[3] = $signed({1'b0, frame.data.wrist_x}) - $signed({1'b0, frame.data.shoulder_x});
    assign vdy[3] = $signed({1'b0, frame.data.wrist_y}) - $signed({1'b0, frame.data.shoulder_y});

    for (genvar v = 0; v < VECS; v++)
    begin : g_lane
        jasm_cordic_lane u_lane (
            .clk  (clk),
            .ctrl (lane_ctrl),
            .step (cnt_reg[STEP_W-1:0]),
            .dx   (vdx[v]),
            .dy   (vdy[v]),
            .z    (vz[v])
        );
    end

    jasm_merge u_merge (
        .clk   (clk),
        .rst_n (rst_n),
        .write (merge_write),
        .z     (vz),
        .sum   (sum),
        .fill  (fill)
    );

    assign span    = $signed({1'b0, pulse_max_reg}) - $signed({1'b0, pulse_min_reg});
    assign div_den = DIV_D_W'(fill);

    for (genvar j = 0; j < JOINTS; j++)
    begin : g_joint
        assign div_num[j] = DIV_N_W'(sum[j]);

        jasm_div u_div (
            .clk  (clk),
            .ctrl (div_ctrl),
            .num  (div_num[j]),
            .den  (div_den),
            .quo  (div_quo[j])
        );

        assign prod_mag[j] = (prod_reg[j] < 0) ? -prod_reg[j] : prod_reg[j];

        always_ff @(posedge clk)
        begin
            if (state_reg == S_MUL)
            begin
                prod_reg[j] <= PROD_W'($signed({1'b0, div_quo[j][ANGLE_W-1:0]}) * span);
            end
            if (state_reg == S_MAP)
            begin
                recip_reg[j] <= MAP_PROD_W'(prod_mag[j][MAP_SHIFT+MAP_N_W-1:MAP_SHIFT])
                                * MAP_RECIP;
            end
        end

        assign map_quo[j] = recip_reg[j][MAP_RECIP_SHIFT+PULSE_W-1:MAP_RECIP_SHIFT];

        assign jpulse[j] = prod_reg[j][PROD_W-1]
            ? pulse_min_reg - map_quo[j]
            : pulse_min_reg + map_quo[j];
    end

    assign gx = $signed({1'b0, frame_reg.thumb_x}) - $signed({1'b0, frame_reg.index_x});
    assign gy = $signed({1'b0, frame_reg.thumb_y}) - $signed({1'b0, frame_reg.index_y});

    always_ff @(posedge clk)
    begin
        sqx_reg <= (2 * COORD_W)'(gx * gx);
        sqy_reg <= (2 * COORD_W)'(gy * gy);
        thr_reg <= grab_distance_reg * grab_distance_reg;
    end

    assign grab = ({1'b0, sqx_reg} + {1'b0, sqy_reg}) < {1'b0, thr_reg};
    assign half = (span + ((span < 0) ? 13'sd1 : 13'sd0)) >>> 1;

    always_comb
    begin
        out_next.shoulder_pulse = jpulse[0];
        out_next.elbow_pulse    = jpulse[1];
        out_next.wrist_pulse    = jpulse[2];
        out_next.grip_pulse     = grab ? pulse_min_reg + half[PULSE_W-1:0] : pulse_min_reg;
        out_next.grab           = grab;
    end

    assign pulse.valid = out_valid_reg;
    assign pulse.data  = out_reg;

    `JASM_ASSERT_NEXT(a_accept_starts_rotation, clk, rst_n, frame.valid && frame.ready, state_reg == S_ROT, "accepted frame did not start the CORDIC lanes")
    `JASM_ASSERT_SAME(a_fill_bounded, clk, rst_n, 1'b1, fill <= FILL_W'(HISTORY_DEPTH), "history fill count exceeds its depth")
    `JASM_ASSERT_NEXT(a_done_presents_result, clk, rst_n, state_reg == S_DONE && !out_valid_reg, out_valid_reg && state_reg == S_IDLE, "finished result was not presented")

endmodule

>>> tb/joint_angle_servo_mapper_test.sv
module joint_angle_servo_mapper_test;
    import jasm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 120;
    localparam int PHASE_ITEMS    = 215;
    localparam int PHASES         = 6;
    localparam int DIRECTED_ROWS  = 14;
    localparam int PENDING_DEPTH  = 8;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    jasm_frame_if frame_ch ();
    jasm_pulse_if pulse_ch ();

    joint_angle_servo_mapper uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .frame     (frame_ch),
        .pulse     (pulse_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    logic [PULSE_W-1:0] pulse_min_m;
    logic [PULSE_W-1:0] pulse_max_m;
    logic [GRAB_W-1:0]  grab_dist_m;
    logic [ANGLE_W-1:0] angle_hist [JOINTS][HISTORY_DEPTH];
    int unsigned        hist_slot;
    int unsigned        hist_fill;

    pulse_t pending_pulses [PENDING_DEPTH];
    int     pending_head = 0;
    int     pending_tail = 0;
    int     pending_count = 0;
    int     mismatches = 0;
    int     idle_cycles = 0;
    bit     quiet = 1'b0;
    bit     hold_request = 1'b0;

    frame_t directed_frames [DIRECTED_ROWS];
    bit     directed_known [DIRECTED_ROWS];
    pulse_t directed_pulse [DIRECTED_ROWS];

    function automatic longint bearing(longint dx, longint dy);
        longint x;
        longint y;
        longint z;
        longint t;
        longint xs;
        longint ys;
        x = dx * 256;
        y = dy * 256;
        z = 0;
        if (x == 0 && y == 0)
        begin
            return 0;
        end
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = longint'(DEG90_Q16);
            end
            else
            begin
                x = -y;
                y = t;
                z = -longint'(DEG90_Q16);
            end
        end
        for (int i = 0; i < CORDIC_STEPS && i < TAB_LEN; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_TABLE[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_TABLE[i];
            end
        end
        return z;
    endfunction

    function automatic logic [ANGLE_W-1:0] vertex_angle(longint ax, longint ay,
                                                        longint bx, longint by,
                                                        longint cx, longint cy);
        longint d;
        d = bearing(cx - bx, cy - by) - bearing(ax - bx, ay - by);
        if (d < 0)
        begin
            d = -d;
        end
        if (d > longint'(DEG180_Q16))
        begin
            d = longint'(DEG360_Q16) - d;
        end
        if (d < 0)
        begin
            d = 0;
        end
        return ANGLE_W'(d >> 8);
    endfunction

    function automatic logic [PULSE_W-1:0] servo_count(longint angle);
        longint span;
        longint p;
        span = longint'(pulse_max_m) - longint'(pulse_min_m);
        p = longint'(pulse_min_m) + (angle * span) / longint'(SPAN_Q88);
        return PULSE_W'(p);
    endfunction

    function automatic pulse_t servo_pulses(frame_t f);
        pulse_t r;
        longint sx, sy, ex, ey, wx, wy, dx, dy;
        longint sum [JOINTS];
        sx = longint'(f.shoulder_x);
        sy = longint'(f.shoulder_y);
        ex = longint'(f.elbow_x);
        ey = longint'(f.elbow_y);
        wx = longint'(f.wrist_x);
        wy = longint'(f.wrist_y);
        angle_hist[0][hist_slot] = vertex_angle(sx, sy, ex, ey, wx, wy);
        angle_hist[1][hist_slot] = vertex_angle(ex, ey, sx, sy, wx, wy);
        angle_hist[2][hist_slot] = vertex_angle(wx, wy, ex, ey, sx, sy);
        hist_slot = (hist_slot + 1 >= HISTORY_DEPTH) ? 0 : hist_slot + 1;
        if (hist_fill < HISTORY_DEPTH)
        begin
            hist_fill++;
        end
        for (int j = 0; j < JOINTS; j++)
        begin
            sum[j] = 0;
            for (int i = 0; i < hist_fill; i++)
            begin
                sum[j] += longint'(angle_hist[j][i]);
            end
            sum[j] = sum[j] / hist_fill;
        end
        r.shoulder_pulse = servo_count(sum[0]);
        r.elbow_pulse = servo_count(sum[1]);
        r.wrist_pulse = servo_count(sum[2]);
        dx = longint'(f.thumb_x) - longint'(f.index_x);
        dy = longint'(f.thumb_y) - longint'(f.index_y);
        r.grab = (dx * dx + dy * dy) < longint'(grab_dist_m) * longint'(grab_dist_m);
        r.grip_pulse = servo_count(r.grab ? 90 * 256 : 0);
        return r;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_PULSE_MIN: pulse_min_m = value[PULSE_W-1:0];
            REG_PULSE_MAX: pulse_max_m = value[PULSE_W-1:0];
            REG_GRAB_DISTANCE: grab_dist_m = value;
            default: ;
        endcase
    endtask

    task automatic send_frame(frame_t f, bit known, pulse_t typed);
        int gap;
        pulse_t predicted;
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            frame_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frame_ch.valid <= 1'b1;
        frame_ch.data <= f;
        do
        begin
            @(posedge clk);
        end
        while (!frame_ch.ready);
        predicted = servo_pulses(f);
        pending_pulses[pending_tail] = known ? typed : predicted;
        pending_tail = (pending_tail + 1) % PENDING_DEPTH;
        pending_count++;
    endtask

    function automatic logic [COORD_W-1:0] near(logic [COORD_W-1:0] base, int spread);
        int v;
        v = int'(base) + $urandom_range(0, 2 * spread) - spread;
        if (v < 0)
        begin
            v = 0;
        end
        if (v > 65535)
        begin
            v = 65535;
        end
        return COORD_W'(v);
    endfunction

    function automatic frame_t random_frame();
        frame_t f;
        int shape;
        int spread;
        f = {$urandom, $urandom, $urandom, $urandom, $urandom};
        shape = $urandom_range(0, 9);
        spread = 1 << $urandom_range(0, 12);
        if (shape == 6)
        begin
            f.elbow_x = near(f.shoulder_x, spread);
            f.elbow_y = near(f.shoulder_y, spread);
            f.wrist_x = near(f.elbow_x, spread);
            f.wrist_y = near(f.elbow_y, spread);
        end
        else if (shape == 7)
        begin
            f.elbow_x = f.shoulder_x;
            f.elbow_y = f.shoulder_y;
            if ($urandom_range(0, 1))
            begin
                f.wrist_x = f.shoulder_x;
                f.wrist_y = f.shoulder_y;
            end
        end
        if (shape >= 5)
        begin
            spread = (grab_dist_m == 0) ? 1 : int'(grab_dist_m);
            f.index_x = near(f.thumb_x, spread);
            f.index_y = near(f.thumb_y, spread);
        end
        return f;
    endfunction

    task automatic settle();
        while (pending_count > 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        directed_frames[0]  = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000};
        directed_frames[1]  = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        directed_frames[2]  = '{16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
                                16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF};
        directed_frames[3]  = '{16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'hFFFF,
                                16'hFFFF, 16'h1234, 16'h1234, 16'h1234, 16'h1234};
        directed_frames[4]  = '{16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h8000,
                                16'h8000, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF};
        directed_frames[5]  = '{16'h8000, 16'h8000, 16'h0000, 16'h9000, 16'h0000,
                                16'h7000, 16'h4000, 16'h4000, 16'h4100, 16'h4100};
        directed_frames[6]  = '{16'h3000, 16'h5000, 16'h3000, 16'h5000, 16'h9000,
                                16'h1000, 16'h0000, 16'h0000, 16'h0CCD, 16'h0000};
        directed_frames[7]  = '{16'h2000, 16'h2000, 16'h6000, 16'h2000, 16'h6000,
                                16'h6000, 16'h0000, 16'h0000, 16'h0CCC, 16'h0000};
        directed_frames[8]  = '{16'h2000, 16'h2000, 16'h6000, 16'h2000, 16'h6000,
                                16'h6000, 16'h5000, 16'h0000, 16'h5000, 16'h0CCD};
        directed_frames[9]  = '{16'hA5A5, 16'h5A5A, 16'h5A5A, 16'hA5A5, 16'hFF00,
                                16'h00FF, 16'hA5A5, 16'h5A5A, 16'h5A5A, 16'hA5A5};
        directed_frames[10] = '{16'h1000, 16'h8000, 16'h8000, 16'h8000, 16'h1000,
                                16'h7FFF, 16'h7000, 16'h7000, 16'h7001, 16'h6FFF};
        directed_frames[11] = '{16'hF000, 16'h0100, 16'h8000, 16'h8000, 16'h0010,
                                16'hFFF0, 16'hFFFF, 16'hFFFF, 16'hF333, 16'hFFFF};
        directed_frames[12] = '{16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                16'h0001, 16'h0001, 16'h0001, 16'h0000, 16'h0000};
        directed_frames[13] = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000,
                                16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000};
        foreach (directed_known[i])
        begin
            directed_known[i] = 1'b0;
            directed_pulse[i] = '0;
        end
        directed_known[0] = 1'b1;
        directed_known[1] = 1'b1;
        directed_pulse[0] = '{150, 150, 150, 375, 1'b1};
        directed_pulse[1] = '{150, 150, 150, 375, 1'b1};
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_PULSE_MIN;
        cfg_data <= '0;
        frame_ch.valid <= 1'b0;
        frame_ch.data <= '0;
        pulse_min_m = PULSE_MIN_RESET;
        pulse_max_m = PULSE_MAX_RESET;
        grab_dist_m = GRAB_DISTANCE_RESET;
        hist_slot = 0;
        hist_fill = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            send_frame(directed_frames[i], directed_known[i], directed_pulse[i]);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            frame_ch.valid <= 1'b0;
            settle();
            case (p)
                1:
                begin
                    write_reg(REG_PULSE_MIN, 16'hF000);
                    write_reg(REG_PULSE_MAX, 16'hFFFF);
                    write_reg(REG_GRAB_DISTANCE, 16'hFFFF);
                    write_reg(REG_UNUSED, 16'h0ABC);
                end
                2:
                begin
                    write_reg(REG_PULSE_MIN, 16'h0FFF);
                    write_reg(REG_PULSE_MAX, 16'h0000);
                    write_reg(REG_GRAB_DISTANCE, 16'h0000);
                end
                3, 4:
                begin
                    write_reg(REG_PULSE_MIN, CFG_W'($urandom));
                    write_reg(REG_PULSE_MAX, CFG_W'($urandom));
                    write_reg(REG_GRAB_DISTANCE, CFG_W'($urandom_range(0, 16384)));
                end
                5:
                begin
                    write_reg(REG_PULSE_MIN, 16'h0FFF);
                    write_reg(REG_PULSE_MAX, 16'h0FFF);
                    write_reg(REG_GRAB_DISTANCE, GRAB_DISTANCE_RESET);
                end
                default: ;
            endcase
            quiet = (p == 4);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 0 && n == 40)
                begin
                    hold_request = 1'b1;
                end
                if (n == PHASE_ITEMS / 2)
                begin
                    quiet = ~quiet;
                end
                send_frame(random_frame(), 1'b0, '0);
            end
        end

        frame_ch.valid <= 1'b0;
        settle();
        if (mismatches == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial
    begin
        int wait_cycles;
        pulse_t got;
        pulse_t want;
        pulse_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                pulse_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                wait_cycles = quiet ? 0 : $urandom_range(0, 8);
                if (wait_cycles > 0)
                begin
                    pulse_ch.ready <= 1'b0;
                    repeat (wait_cycles) @(posedge clk);
                end
            end
            pulse_ch.ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!pulse_ch.valid);
            got = pulse_ch.data;
            if (pending_count == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected pulse transfer %p", got);
                end
            end
            else
            begin
                want = pending_pulses[pending_head];
                pending_head = (pending_head + 1) % PENDING_DEPTH;
                pending_count--;
                if (got.shoulder_pulse !== want.shoulder_pulse
                    || got.elbow_pulse !== want.elbow_pulse
                    || got.wrist_pulse !== want.wrist_pulse
                    || got.grip_pulse !== want.grip_pulse
                    || got.grab !== want.grab)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("pulse mismatch: expected %p, got %p", want, got);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((frame_ch.valid && frame_ch.ready) || (pulse_ch.valid && pulse_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
